/* src/lcd4_pkg.sv */
// Shared types, command codes, and wake-up tables for the 4-bit LCD write sequencer.
`default_nettype none

package lcd4_pkg;

    // Request command codes.
    localparam logic [1:0] CMD_WAKE  = 2'd0;
    localparam logic [1:0] CMD_INSTR = 2'd1;
    localparam logic [1:0] CMD_DATA  = 2'd2;

    // Timing constants in microseconds.
    localparam logic [13:0] POWER_UP_WAIT_US = 14'd16000;
    localparam logic [16:0] INSTR_WAIT_US    = 17'd40;
    localparam logic [16:0] DATA_WAIT_US     = 17'd43;

    // Width of the wait sum and index of the final wake-up command.
    localparam int unsigned WAIT_W    = 17;
    localparam logic [3:0]  WAKE_LAST = 4'd9;

    // Request and transfer payloads.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  byte_value;
        logic [15:0] extra_wait_us;
    } req_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [13:0] wait_before_us;
        logic [16:0] wait_after_us;
        logic        last_transfer;
    } xfer_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_HI,
        ST_LO
    } state_t;

    // Instruction bytes of the power-on sequence.
    function automatic logic [7:0] wake_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h30;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h80;
            4'd9:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Extra settle time after each command of the power-on sequence.
    function automatic logic [15:0] wake_extra(input logic [3:0] idx);
        logic [15:0] w;
        case (idx)
            4'd0:    w = 16'd5000;
            4'd1:    w = 16'd150;
            4'd2:    w = 16'd1;
            4'd6:    w = 16'd2000;
            4'd9:    w = 16'd40;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/lcd4_serial_add.sv */
// Bit-serial adder that sums two operands one bit per cycle, LSB first.
`default_nettype none

module lcd4_serial_add #(
    parameter int unsigned WIDTH = 17
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] op_a,
    input  wire logic [WIDTH-1:0] op_b,
    output logic                  done,
    output logic [WIDTH-1:0]      sum
);

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] sum_reg;
    logic             carry_reg;
    logic             bit_sum;
    logic             bit_carry;

    // One full-adder cell works on the low bits of the operand shifters.
    assign bit_sum   = a_reg[0] ^ b_reg[0] ^ carry_reg;
    assign bit_carry = (a_reg[0] & b_reg[0]) | (carry_reg & (a_reg[0] ^ b_reg[0]));

    // Bit counter; the sum is complete when it reaches zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(WIDTH);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Operand and sum shifters.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg     <= op_a;
            b_reg     <= op_b;
            carry_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            a_reg     <= {1'b0, a_reg[WIDTH-1:1]};
            b_reg     <= {1'b0, b_reg[WIDTH-1:1]};
            carry_reg <= bit_carry;
            sum_reg   <= {bit_sum, sum_reg[WIDTH-1:1]};
        end
    end

    assign done = (cnt_reg == '0);
    assign sum  = sum_reg;

endmodule

`default_nettype wire

/* src/lcd_4bit_write_sequencer.sv */
// Top level of the 4-bit character LCD write sequencer.
//
// The s_ channel takes one request: a wake-up, an instruction byte, or a
// data byte. The m_ channel delivers two nibble transfers per byte, high
// nibble first, each with its register-select level, the wait before it,
// the wait after its enable pulse, and a flag on the final transfer.
// A byte request holds the sequencer from acceptance to the next
// acceptance through the accept, the load, and a bit-serial add of the
// base wait and the extra wait, which sets the pace. With no stall the
// high nibble is registered from the HI state after the load, and the low
// nibble from the LO state once the add is complete. A wake-up request
// replays the ten power-on bytes. A new request is taken only once the
// previous one has handed its last transfer to the output register;
// command code 3 is taken and dropped with no transfers. Reset returns the
// sequencer to idle and empties the output register. When the receiver
// stalls, the finished transfer waits in the output register and the
// sequencer holds until that register frees.
`default_nettype none

module lcd_4bit_write_sequencer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lcd4_pkg::req_t s_req,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lcd4_pkg::xfer_t     m_xfer
);

    lcd4_pkg::state_t state_reg;
    lcd4_pkg::state_t state_next;
    logic [1:0]       cmd_reg;
    logic [7:0]       byte_sh_reg;
    logic [15:0]      extra_reg;
    logic [3:0]       idx_reg;
    logic             m_valid_reg;
    lcd4_pkg::xfer_t  m_xfer_reg;

    logic                          is_wake;
    logic                          is_data;
    logic                          out_free;
    logic                          req_ok;
    logic                          add_start;
    logic                          add_done;
    logic                          emit_hi;
    logic                          emit_lo;
    logic [7:0]                    cur_byte;
    logic [15:0]                   cur_extra;
    logic [lcd4_pkg::WAIT_W-1:0]   base_wait;
    logic [lcd4_pkg::WAIT_W-1:0]   wait_sum;

    assign is_wake  = (cmd_reg == lcd4_pkg::CMD_WAKE);
    assign is_data  = (cmd_reg == lcd4_pkg::CMD_DATA);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == lcd4_pkg::ST_IDLE);
    assign req_ok   = (s_req.command == lcd4_pkg::CMD_WAKE)
                   || (s_req.command == lcd4_pkg::CMD_INSTR)
                   || (s_req.command == lcd4_pkg::CMD_DATA);

    // Byte and extra wait of the current step: table entry or request fields.
    assign cur_byte  = is_wake ? lcd4_pkg::wake_byte(idx_reg) : byte_sh_reg;
    assign cur_extra = is_wake ? lcd4_pkg::wake_extra(idx_reg) : extra_reg;
    assign base_wait = is_data ? lcd4_pkg::DATA_WAIT_US : lcd4_pkg::INSTR_WAIT_US;

    // Serial adder for the wait after the low nibble.
    lcd4_serial_add #(
        .WIDTH (lcd4_pkg::WAIT_W)
    ) u_add (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (add_start),
        .op_a    (base_wait),
        .op_b    ({1'b0, cur_extra}),
        .done    (add_done),
        .sum     (wait_sum)
    );

    // Next state and step controls.
    always_comb begin
        state_next = state_reg;
        add_start  = 1'b0;
        emit_hi    = 1'b0;
        emit_lo    = 1'b0;
        unique case (state_reg)
            lcd4_pkg::ST_IDLE: begin
                if (s_valid && req_ok) begin
                    state_next = lcd4_pkg::ST_LOAD;
                end
            end
            lcd4_pkg::ST_LOAD: begin
                add_start  = 1'b1;
                state_next = lcd4_pkg::ST_HI;
            end
            lcd4_pkg::ST_HI: begin
                if (out_free) begin
                    emit_hi    = 1'b1;
                    state_next = lcd4_pkg::ST_LO;
                end
            end
            lcd4_pkg::ST_LO: begin
                if (out_free && add_done) begin
                    emit_lo = 1'b1;
                    if (is_wake && idx_reg != lcd4_pkg::WAKE_LAST) begin
                        state_next = lcd4_pkg::ST_LOAD;
                    end else begin
                        state_next = lcd4_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = lcd4_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lcd4_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_hi || emit_lo) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request fields, the nibble shifter, and the step index.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_req.command;
            byte_sh_reg <= s_req.byte_value;
            extra_reg   <= s_req.extra_wait_us;
            idx_reg     <= '0;
        end else if (state_reg == lcd4_pkg::ST_LOAD) begin
            byte_sh_reg <= cur_byte;
        end else if (emit_hi) begin
            byte_sh_reg <= {byte_sh_reg[3:0], 4'h0};
        end else if (emit_lo) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Output register: one nibble transfer at a time on the m_ side.
    always_ff @(posedge aclk) begin
        if (emit_hi) begin
            m_xfer_reg.reg_select     <= is_data;
            m_xfer_reg.nibble         <= byte_sh_reg[7:4];
            m_xfer_reg.wait_before_us <= (is_wake && idx_reg == '0)
                                         ? lcd4_pkg::POWER_UP_WAIT_US : 14'd0;
            m_xfer_reg.wait_after_us  <= '0;
            m_xfer_reg.last_transfer  <= 1'b0;
        end else if (emit_lo) begin
            m_xfer_reg.reg_select     <= is_data;
            m_xfer_reg.nibble         <= byte_sh_reg[7:4];
            m_xfer_reg.wait_before_us <= '0;
            m_xfer_reg.wait_after_us  <= wait_sum;
            m_xfer_reg.last_transfer  <= !is_wake || (idx_reg == lcd4_pkg::WAKE_LAST);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_xfer  = m_xfer_reg;

    // A final transfer always carries at least the instruction settle time.
    a_last_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_xfer.last_transfer |-> m_xfer.wait_after_us >= 17'd40)
        else $error("final transfer has a short settle time");

    // The power-up delay only leads the first wake-up nibble.
    a_power_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_xfer.wait_before_us != 14'd0
            |-> !m_xfer.reg_select && m_xfer.nibble == 4'h3)
        else $error("power-up delay on an unexpected transfer");

    // Data transfers settle for at least 43 us after the low nibble.
    a_data_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_xfer.reg_select
            |-> m_xfer.wait_after_us == 17'd0 || m_xfer.wait_after_us >= 17'd43)
        else $error("data transfer settle time below minimum");

    // The adder is idle whenever a new request can be taken.
    a_add_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> add_done)
        else $error("adder busy while idle");

    // A low nibble is sent only once the wait sum is complete.
    a_emit_lo: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_lo |-> add_done && state_reg == lcd4_pkg::ST_LO)
        else $error("low nibble sent before the wait sum was ready");

endmodule

`default_nettype wire
